FILE: rtl/idtf_pkg.sv
// Shared constants for the integer to decimal text formatter.
package idtf_pkg;

  // Payload widths.
  localparam int unsigned VALUE_W   = 32;
  localparam int unsigned CHAR_W    = 7;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 8;

  // A 32-bit magnitude has at most ten decimal digits.
  localparam int unsigned NUM_DIGITS = 10;
  localparam int unsigned BCD_W      = 4 * NUM_DIGITS;
  localparam logic [3:0]  MAX_PLACES = 4'd9;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMAL_PLACES = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_FILL      = 8'd3;

  // ASCII codes.
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_DOT   = 7'h2E;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;

endpackage

FILE: rtl/idtf_if.sv
// Valid/ready channel interfaces for the formatter: value in, characters out, register writes.
interface idtf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [idtf_pkg::VALUE_W-1:0] value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface idtf_out_if;
  logic                         valid;
  logic                         ready;
  logic [idtf_pkg::CHAR_W-1:0]  char_code;
  logic                         last;
  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface idtf_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [idtf_pkg::CFG_IDX_W-1:0] index;
  logic [idtf_pkg::CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/integer_to_decimal_text_formatter.sv
// Integer to decimal ASCII text formatter with sign, fill, field width and decimal point.
//
//   Channel  Dir  Payload              Notes
//   in_i     in   value[31:0]          one request per number, taken only when idle
//   out_o    out  char_code[6:0],last  one request per character, most significant first
//   cfg_i    in   index[7:0],data[7:0] register write, always ready
//
// A number enters, goes through bit-serial double dabble conversion, skipping of up to
// nine leading zero digits, sizing of the fill and the fill stage, and then leaves
// one character per output transfer (at most MAX_CHARS+1 when MAX_CHARS is 16).
// The conversion loop shifts in one magnitude bit per cycle.
// Reset clears the configuration registers and the control state; the datapath is not reset.
// A stalled output holds its character and the sequencer waits until it is taken;
// the next number is accepted while the final character still waits.
module integer_to_decimal_text_formatter #(
  parameter int unsigned MAX_CHARS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  idtf_in_if.sink    in_i,
  idtf_out_if.source out_o,
  idtf_cfg_if.sink   cfg_i
);
  import idtf_pkg::*;

  // Sequencer state codes.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CONV = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_SIGN = 3'd3;
  localparam logic [2:0] S_FILL = 3'd4;
  localparam logic [2:0] S_DIG  = 3'd5;
  localparam logic [2:0] S_DOT  = 3'd6;

  localparam logic [5:0] MaxCharsW = 6'(MAX_CHARS);

  // Configuration registers.
  logic [4:0] field_width_q;
  logic [3:0] decimal_places_q;
  logic       signed_mode_q;
  logic       zero_fill_q;

  // Sequencer and datapath registers.
  logic [2:0]         state_q, state_d;
  logic [VALUE_W-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]   bcd_q, bcd_d;
  logic [4:0]         bit_cnt_q, bit_cnt_d;
  logic [3:0]         dig_cnt_q, dig_cnt_d;
  logic [3:0]         places_q, places_d;
  logic               neg_q, neg_d;
  logic               zfill_q, zfill_d;
  logic [5:0]         fill_cnt_q, fill_cnt_d;

  // Output register.
  logic              ovalid_q, ovalid_d;
  logic [CHAR_W-1:0] ochar_q, ochar_d;
  logic              olast_q, olast_d;

  logic              can_load;
  logic              in_fire;
  logic [BCD_W-1:0]  bcd_adj;
  logic [5:0]        width_eff;
  logic [5:0]        core_len;
  logic [4:0]        min_digits;

  assign in_i.ready      = (state_q == S_IDLE);
  assign in_fire         = in_i.valid && in_i.ready;
  assign cfg_i.ready     = 1'b1;
  assign out_o.valid     = ovalid_q;
  assign out_o.char_code = ochar_q;
  assign out_o.last      = olast_q;

  assign can_load = !ovalid_q || out_o.ready;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_width_q    <= '0;
      decimal_places_q <= '0;
      signed_mode_q    <= 1'b0;
      zero_fill_q      <= 1'b0;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_FIELD_WIDTH:    field_width_q    <= cfg_i.data[4:0];
        REG_DECIMAL_PLACES: decimal_places_q <= cfg_i.data[3:0];
        REG_SIGNED_MODE:    signed_mode_q    <= cfg_i.data[0];
        REG_ZERO_FILL:      zero_fill_q      <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  // Double dabble correction: each BCD digit of five or more gets three added.
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                    : bcd_q[4*i +: 4];
    end
  end

  // Field width saturates at MAX_CHARS; text length excludes the sign.
  assign width_eff  = ({1'b0, field_width_q} > MaxCharsW) ? MaxCharsW : {1'b0, field_width_q};
  assign core_len   = {2'b00, dig_cnt_q} + {5'd0, (places_q != 4'd0)};
  assign min_digits = {1'b0, places_q} + 5'd1;

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    bin_d      = bin_q;
    bcd_d      = bcd_q;
    bit_cnt_d  = bit_cnt_q;
    dig_cnt_d  = dig_cnt_q;
    places_d   = places_q;
    neg_d      = neg_q;
    zfill_d    = zfill_q;
    fill_cnt_d = fill_cnt_q;
    ovalid_d   = ovalid_q && !out_o.ready;
    ochar_d    = ochar_q;
    olast_d    = olast_q;

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          neg_d     = signed_mode_q && in_i.value[VALUE_W-1];
          bin_d     = neg_d ? (~in_i.value + 32'd1) : in_i.value;
          bcd_d     = '0;
          bit_cnt_d = 5'd31;
          places_d  = (decimal_places_q > MAX_PLACES) ? MAX_PLACES : decimal_places_q;
          zfill_d   = zero_fill_q;
          state_d   = S_CONV;
        end
      end
      // One magnitude bit shifts into the BCD register per cycle.
      S_CONV: begin
        {bcd_d, bin_d} = {bcd_adj, bin_q} << 1;
        bit_cnt_d      = bit_cnt_q - 5'd1;
        if (bit_cnt_q == 5'd0) begin
          dig_cnt_d = 4'(NUM_DIGITS);
          state_d   = S_NORM;
        end
      end
      // Drop leading zero digits, keeping at least places+1 digits.
      S_NORM: begin
        if (dig_cnt_q > 4'd1 && {1'b0, dig_cnt_q} > min_digits &&
            bcd_q[BCD_W-1 -: 4] == 4'd0) begin
          bcd_d     = bcd_q << 4;
          dig_cnt_d = dig_cnt_q - 4'd1;
        end else begin
          fill_cnt_d = (width_eff > core_len) ? width_eff - core_len : 6'd0;
          state_d    = neg_q ? S_SIGN : S_FILL;
        end
      end
      S_SIGN: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          ochar_d  = ASCII_MINUS;
          olast_d  = 1'b0;
          state_d  = S_FILL;
        end
      end
      S_FILL: begin
        if (fill_cnt_q == 6'd0) begin
          state_d = S_DIG;
        end else if (can_load) begin
          ovalid_d   = 1'b1;
          ochar_d    = zfill_q ? ASCII_ZERO : ASCII_SPACE;
          olast_d    = 1'b0;
          fill_cnt_d = fill_cnt_q - 6'd1;
        end
      end
      // Digits leave from the top of the BCD register, one per request.
      S_DIG: begin
        if (can_load) begin
          ovalid_d  = 1'b1;
          ochar_d   = ASCII_ZERO | {3'b000, bcd_q[BCD_W-1 -: 4]};
          olast_d   = (dig_cnt_q == 4'd1);
          bcd_d     = bcd_q << 4;
          dig_cnt_d = dig_cnt_q - 4'd1;
          if (dig_cnt_q == 4'd1) begin
            state_d = S_IDLE;
          end else if (places_q != 4'd0 && dig_cnt_d == places_q) begin
            state_d = S_DOT;
          end
        end
      end
      S_DOT: begin
        if (can_load) begin
          ovalid_d = 1'b1;
          ochar_d  = ASCII_DOT;
          olast_d  = 1'b0;
          state_d  = S_DIG;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath and output payload.
  always_ff @(posedge clk_i) begin
    bin_q      <= bin_d;
    bcd_q      <= bcd_d;
    bit_cnt_q  <= bit_cnt_d;
    dig_cnt_q  <= dig_cnt_d;
    places_q   <= places_d;
    neg_q      <= neg_d;
    zfill_q    <= zfill_d;
    fill_cnt_q <= fill_cnt_d;
    ochar_q    <= ochar_d;
    olast_q    <= olast_d;
  end

endmodule
